// ----- hw/rtl/bps_pkg.sv -----
`default_nettype none

package bps_pkg;

	// sizing of the pattern cells and of the position counter
	localparam int PATTERN_MAX = 64;
	localparam int POS_BITS    = 24;

	localparam int LEN_W = $clog2(PATTERN_MAX + 1);
	localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

	// fixed field widths on the channels
	localparam int BYTE_W    = 8;
	localparam int IN_POS_W  = 24;
	localparam int OUT_POS_W = 24;

	// configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_MATCH_ONLY = 1'b0;

	// request kinds
	localparam logic REQ_PATTERN = 1'b0;
	localparam logic REQ_TEXT    = 1'b1;

	typedef struct packed {
		logic                req_type;
		logic [BYTE_W-1:0]   data_byte;
		logic                last;
		logic [IN_POS_W-1:0] start_pos;
	} req_t;

	typedef struct packed {
		logic                 found;
		logic [OUT_POS_W-1:0] position;
		logic                 pattern_error;
	} res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bps_ifs.sv -----
`default_nettype none

// request channel: pattern and text bytes
interface bps_req_if import bps_pkg::*; ();
	logic valid;
	logic ready;
	req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// result channel: at most one report per text
interface bps_res_if import bps_pkg::*; ();
	logic valid;
	logic ready;
	res_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/byte_pattern_search_unit.sv -----
// byte pattern search unit
//
// req channel carries pattern bytes (req_type 0) and text bytes (req_type 1),
// each with a last flag; start_pos is taken from the first byte of a text.
// A pattern byte arriving after a closed pattern begins a new pattern. Each
// text gives at most one transfer on the res channel: the earliest match
// position (saturating), or not found at the last text byte, with
// pattern_error set for an empty or over-long pattern. The user must write
// match_only at APB byte address 0 only while idle; the block does not check.
//
// A byte is taken into the input register at its transfer; the compare
// across all pattern cells runs on that register and loads the result
// register once it is free; res is driven from the result register.
// Throughput: one byte per cycle while res is not stalled, set by the
// single row of compare cells. When res is stalled with a result waiting
// in the output register, the input register holds its byte and req.ready
// drops, whether or not that byte gives a result.
// Reset (arst_n low) closes the pattern, ends any text and empties both
// registers; pattern cells are not cleared and no sweep follows reset.

`default_nettype none

module byte_pattern_search_unit import bps_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	bps_req_if.sink                 req,
	bps_res_if.source               res,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready
);

	localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

	// configuration
	logic match_only_q;

	// input stage
	logic valid_s1;
	req_t req_s1;

	// pattern and search state
	logic [BYTE_W-1:0]      store_q [PATTERN_MAX];
	logic [LEN_W-1:0]       len_q;
	logic                   ovf_q;
	logic                   closed_q;
	logic [PATTERN_MAX-1:0] hits_q;
	logic [POS_BITS-1:0]    count_q;
	logic [POS_BITS-1:0]    base_q;
	logic                   text_active_q;
	logic                   rep_q;

	// output register
	logic res_valid_q;
	res_t res_q;

	// stage control
	logic adv;
	logic emit;
	res_t emit_res;

	// text byte evaluation
	logic                   first_txt;
	logic [POS_BITS-1:0]    count_cur;
	logic [POS_BITS-1:0]    base_cur;
	logic                   rep_cur;
	logic [PATTERN_MAX-1:0] hits_cur;
	logic [PATTERN_MAX-1:0] hits_calc;
	logic                   bad;
	logic                   inject;
	logic                   search;
	logic [LEN_W-1:0]       len_m1;
	logic                   matched;
	logic [POS_BITS-1:0]    rel;
	logic [POS_BITS:0]      pos_sum;
	logic [POS_BITS-1:0]    pos;
	logic [POS_BITS-1:0]    count_inc;

	// pattern byte evaluation
	logic [LEN_W-1:0] len_eff;
	logic             room;

	// apb port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MATCH_ONLY) ? PDATA_W'(match_only_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_only_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_MATCH_ONLY) begin
			match_only_q <= pwdata[0];
		end
	end

	// handshake: the input register moves on when the output register is free
	assign adv       = valid_s1 && (!res_valid_q || res.ready);
	assign req.ready = !valid_s1 || adv;
	assign res.valid = res_valid_q;
	assign res.payload = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1 <= req.payload;
		end
	end

	// text state as seen by this byte (a new text starts from scratch)
	assign first_txt = !text_active_q;
	assign count_cur = first_txt ? '0 : count_q;
	assign base_cur  = first_txt ? POS_BITS'(req_s1.start_pos) : base_q;
	assign rep_cur   = first_txt ? 1'b0 : rep_q;
	assign hits_cur  = first_txt ? '0 : hits_q;

	assign bad    = (len_q == '0) || ovf_q;
	assign inject = !match_only_q || (count_cur == '0);
	assign search = !rep_cur && !bad;

	// one prefix cell per pattern byte
	always_comb begin
		for (int k = 0; k < PATTERN_MAX; k++) begin
			hits_calc[k] = ((k == 0) ? inject : hits_cur[(k == 0) ? 0 : k - 1])
				&& (store_q[k] == req_s1.data_byte)
				&& (LEN_W'(k) < len_q);
		end
	end

	assign len_m1  = len_q - 1'b1;
	assign matched = search && hits_calc[len_m1[IDX_W-1:0]];

	// match start, saturating at the top of the position range
	assign rel     = count_cur - (POS_BITS'(len_q) - 1'b1);
	assign pos_sum = {1'b0, base_cur} + {1'b0, rel};
	assign pos     = pos_sum[POS_BITS] ? POS_MAX : pos_sum[POS_BITS-1:0];

	assign count_inc = (count_cur < POS_MAX) ? count_cur + 1'b1 : count_cur;

	// result of this byte
	always_comb begin
		emit     = 1'b0;
		emit_res = '0;
		if (req_s1.req_type == REQ_TEXT) begin
			if (matched) begin
				emit              = 1'b1;
				emit_res.found    = 1'b1;
				emit_res.position = OUT_POS_W'(pos);
			end else if (req_s1.last && !rep_cur) begin
				emit                   = 1'b1;
				emit_res.pattern_error = bad;
			end
		end
	end

	// pattern fill
	assign len_eff = closed_q ? '0 : len_q;
	assign room    = len_eff < LEN_W'(PATTERN_MAX);

	always_ff @(posedge clk) begin
		if (adv && req_s1.req_type == REQ_PATTERN && room) begin
			store_q[len_eff[IDX_W-1:0]] <= req_s1.data_byte;
		end
	end

	// pattern and text state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q         <= '0;
			ovf_q         <= 1'b0;
			closed_q      <= 1'b1;
			hits_q        <= '0;
			count_q       <= '0;
			base_q        <= '0;
			text_active_q <= 1'b0;
			rep_q         <= 1'b0;
		end else if (adv) begin
			if (req_s1.req_type == REQ_PATTERN) begin
				text_active_q <= 1'b0;
				if (room) begin
					len_q <= len_eff + 1'b1;
					ovf_q <= closed_q ? 1'b0 : ovf_q;
				end else begin
					len_q <= len_eff;
					ovf_q <= 1'b1;
				end
				closed_q <= req_s1.last;
			end else begin
				base_q        <= base_cur;
				count_q       <= count_inc;
				hits_q        <= search ? hits_calc : hits_cur;
				rep_q         <= rep_cur || matched || req_s1.last;
				text_active_q <= !req_s1.last;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv && emit) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			res_q <= emit_res;
		end
	end

	// checks
	a_found_no_error: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !(res.payload.found && res.payload.pattern_error))
		else $error("match reported together with a pattern error");

	a_miss_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.payload.found |-> res.payload.position == '0)
		else $error("not-found result carries a position");

	a_pattern_ends_text: assert property (@(posedge clk) disable iff (!arst_n)
		adv && req_s1.req_type == REQ_PATTERN |=> !text_active_q)
		else $error("text still active after a pattern byte");

	a_report_once: assert property (@(posedge clk) disable iff (!arst_n)
		adv && emit |=> rep_q && res_valid_q)
		else $error("result emitted without marking the text reported");

endmodule

`default_nettype wire
